[rtl/core/ifmt_pkg.sv]
// Package for the integer to ASCII formatter: mode codes, controller states,
// character constants and the digit-to-character lookup.
// It has no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ifmt_pkg;

  localparam int unsigned ModeW    = 3;
  localparam int unsigned ValueW   = 64;
  localparam int unsigned CharW    = 8;
  localparam int unsigned InDataW  = 72;
  localparam int unsigned DigW     = 64;
  localparam int unsigned DecW     = 32;
  localparam int unsigned DecDigs  = 10;
  localparam int unsigned HexDigs  = 8;
  localparam int unsigned PtrDigs  = 16;

  localparam logic [ModeW-1:0] MODE_CHAR = 3'd0;
  localparam logic [ModeW-1:0] MODE_SDEC = 3'd1;
  localparam logic [ModeW-1:0] MODE_UDEC = 3'd2;
  localparam logic [ModeW-1:0] MODE_HEXL = 3'd3;
  localparam logic [ModeW-1:0] MODE_HEXU = 3'd4;
  localparam logic [ModeW-1:0] MODE_PTR  = 3'd5;

  localparam logic [CharW-1:0] CH_ZERO  = 8'h30;
  localparam logic [CharW-1:0] CH_X     = 8'h78;
  localparam logic [CharW-1:0] CH_MINUS = 8'h2d;
  localparam logic [CharW-1:0] CH_LOWA  = 8'h61;
  localparam logic [CharW-1:0] CH_UPA   = 8'h41;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DABBLE,
    ST_SKIP,
    ST_PREFIX,
    ST_DIGITS,
    ST_CHAR
  } state_t;

  function automatic logic [CharW-1:0] digit_char(input logic [3:0] d, input logic upper);
    logic [CharW-1:0] base;
    base = upper ? CH_UPA : CH_LOWA;
    if (d < 4'd10) begin
      digit_char = CH_ZERO + {4'd0, d};
    end else begin
      digit_char = base + {4'd0, d} - 8'd10;
    end
  endfunction

endpackage

`default_nettype wire

[rtl/core/integer_to_ascii_formatter.sv]
// Integer to ASCII formatter: one request in, a stream of characters out,
// most significant character first, with tlast on the final one.
// Depends on ifmt_pkg.
// Decimal items go through double dabble and then a leading-zero skip, hex
// and pointer items through the skip alone, character items through neither.
// A new item is taken once the previous item's characters are all in the
// output register; requests with an unused mode code are dropped. Reset
// clears the controller and the output valid flag.
`timescale 1ns / 1ps
`default_nettype none

module integer_to_ascii_formatter (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               in_tvalid,
  output logic                              in_tready,
  // Fields from bit 0: mode[2:0], value[66:3], zero fill[71:67].
  input  wire  [ifmt_pkg::InDataW-1:0]      in_tdata,
  output logic                              out_tvalid,
  input  wire                               out_tready,
  // Fields from bit 0: char_out[7:0].
  output logic [ifmt_pkg::CharW-1:0]        out_tdata,
  output logic                              out_tlast
);

  localparam int unsigned DW = ifmt_pkg::DigW;
  localparam int unsigned BW = ifmt_pkg::DecW;

  ifmt_pkg::state_t state_r, state_nxt;
  logic [ifmt_pkg::ModeW-1:0] mode_r, mode_nxt;
  logic [DW-1:0]              dig_r, dig_nxt;
  logic [BW-1:0]              bin_r, bin_nxt;
  logic [4:0]                 cnt_r, cnt_nxt;
  logic [4:0]                 ndig_r, ndig_nxt;
  logic [1:0]                 pre_r, pre_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic [ifmt_pkg::CharW-1:0] out_data_r, out_data_nxt;
  logic                       out_last_r, out_last_nxt;

  logic [ifmt_pkg::ModeW-1:0]  in_mode;
  logic [ifmt_pkg::ValueW-1:0] in_value;
  logic [BW-1:0]               low32;
  logic [BW-1:0]               mag;
  logic                        out_load;
  logic [4*ifmt_pkg::DecDigs-1:0] bcd_adj;

  assign in_mode  = in_tdata[ifmt_pkg::ModeW-1:0];
  assign in_value = in_tdata[ifmt_pkg::ModeW +: ifmt_pkg::ValueW];
  assign low32    = in_value[BW-1:0];
  assign mag      = ~low32 + 32'd1;
  assign out_load = !out_valid_r || out_tready;

  assign in_tready  = (state_r == ifmt_pkg::ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  always_comb begin
    for (int i = 0; i < ifmt_pkg::DecDigs; i++) begin
      logic [3:0] d;
      d = dig_r[DW-4*ifmt_pkg::DecDigs + 4*i +: 4];
      bcd_adj[4*i +: 4] = (d >= 4'd5) ? d + 4'd3 : d;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ifmt_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    mode_r     <= mode_nxt;
    dig_r      <= dig_nxt;
    bin_r      <= bin_nxt;
    cnt_r      <= cnt_nxt;
    ndig_r     <= ndig_nxt;
    pre_r      <= pre_nxt;
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    mode_nxt      = mode_r;
    dig_nxt       = dig_r;
    bin_nxt       = bin_r;
    cnt_nxt       = cnt_r;
    ndig_nxt      = ndig_r;
    pre_nxt       = pre_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;

    unique case (state_r)
      ifmt_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          mode_nxt = in_mode;
          cnt_nxt  = 5'd0;
          pre_nxt  = 2'd0;
          unique case (in_mode)
            ifmt_pkg::MODE_CHAR: begin
              dig_nxt   = {in_value[ifmt_pkg::CharW-1:0], {(DW-ifmt_pkg::CharW){1'b0}}};
              state_nxt = ifmt_pkg::ST_CHAR;
            end
            ifmt_pkg::MODE_SDEC, ifmt_pkg::MODE_UDEC: begin
              dig_nxt   = '0;
              ndig_nxt  = 5'(ifmt_pkg::DecDigs);
              state_nxt = ifmt_pkg::ST_DABBLE;
              if (in_mode == ifmt_pkg::MODE_SDEC && low32[BW-1]) begin
                bin_nxt = mag;
                pre_nxt = 2'd1;
              end else begin
                bin_nxt = low32;
              end
            end
            ifmt_pkg::MODE_HEXL, ifmt_pkg::MODE_HEXU: begin
              dig_nxt   = {low32, {(DW-BW){1'b0}}};
              ndig_nxt  = 5'(ifmt_pkg::HexDigs);
              state_nxt = ifmt_pkg::ST_SKIP;
            end
            ifmt_pkg::MODE_PTR: begin
              dig_nxt   = in_value;
              ndig_nxt  = 5'(ifmt_pkg::PtrDigs);
              pre_nxt   = 2'd2;
              state_nxt = ifmt_pkg::ST_SKIP;
            end
            default: begin
              state_nxt = ifmt_pkg::ST_IDLE;
            end
          endcase
        end
      end
      ifmt_pkg::ST_DABBLE: begin
        dig_nxt = {bcd_adj[4*ifmt_pkg::DecDigs-2:0], bin_r[BW-1],
                   dig_r[DW-4*ifmt_pkg::DecDigs-1:0]};
        bin_nxt = {bin_r[BW-2:0], 1'b0};
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'(BW-1)) begin
          state_nxt = ifmt_pkg::ST_SKIP;
        end
      end
      ifmt_pkg::ST_SKIP: begin
        if (dig_r[DW-1 -: 4] == 4'd0 && ndig_r > 5'd1) begin
          dig_nxt  = {dig_r[DW-5:0], 4'd0};
          ndig_nxt = ndig_r - 5'd1;
        end else if (pre_r != 2'd0) begin
          state_nxt = ifmt_pkg::ST_PREFIX;
        end else begin
          state_nxt = ifmt_pkg::ST_DIGITS;
        end
      end
      ifmt_pkg::ST_PREFIX: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          out_last_nxt  = 1'b0;
          if (mode_r == ifmt_pkg::MODE_PTR) begin
            out_data_nxt = (pre_r == 2'd2) ? ifmt_pkg::CH_ZERO : ifmt_pkg::CH_X;
          end else begin
            out_data_nxt = ifmt_pkg::CH_MINUS;
          end
          pre_nxt = pre_r - 2'd1;
          if (pre_r == 2'd1) begin
            state_nxt = ifmt_pkg::ST_DIGITS;
          end
        end
      end
      ifmt_pkg::ST_DIGITS: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = ifmt_pkg::digit_char(dig_r[DW-1 -: 4],
                                               mode_r == ifmt_pkg::MODE_HEXU);
          out_last_nxt  = (ndig_r == 5'd1);
          dig_nxt       = {dig_r[DW-5:0], 4'd0};
          ndig_nxt      = ndig_r - 5'd1;
          if (ndig_r == 5'd1) begin
            state_nxt = ifmt_pkg::ST_IDLE;
          end
        end
      end
      ifmt_pkg::ST_CHAR: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = dig_r[DW-1 -: ifmt_pkg::CharW];
          out_last_nxt  = 1'b1;
          state_nxt     = ifmt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = ifmt_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

[verif/integer_to_ascii_formatter_tb.sv]
// Self-checking testbench for integer_to_ascii_formatter: conversion requests are
// streamed in with random gaps and every character out is checked against a prediction.
// Depends on ifmt_pkg and the integer_to_ascii_formatter RTL.
`timescale 1ns / 1ps

module integer_to_ascii_formatter_tb;

  localparam int unsigned IdleLimit  = 4000;
  localparam int unsigned RandomReqs = 235;
  localparam int unsigned MaxGap     = 17;
  localparam int unsigned LongHold   = 400;

  typedef struct packed {
    logic [ifmt_pkg::CharW-1:0] ch;
    logic                       last;
  } char_item_t;

  class conversion_checker;
    char_item_t  expected_chars[$];
    int unsigned mismatches;

    function new();
      mismatches = 0;
    endfunction

    function void note_request(logic [ifmt_pkg::ModeW-1:0] mode,
                               logic [ifmt_pkg::ValueW-1:0] value);
      logic [ifmt_pkg::CharW-1:0] text[$];
      logic [ifmt_pkg::CharW-1:0] digs[$];
      logic [ifmt_pkg::ValueW-1:0] mag;
      logic [31:0] low32;
      int unsigned radix;
      int idx;
      bit upper;
      string digits_lo;
      string digits_hi;
      char_item_t item;
      digits_lo = "0123456789abcdef";
      digits_hi = "0123456789ABCDEF";
      low32 = value[31:0];
      mag = {32'd0, low32};
      radix = 16;
      upper = 1'b0;
      case (mode)
        ifmt_pkg::MODE_CHAR: text.push_back(value[7:0]);
        ifmt_pkg::MODE_SDEC: begin
          radix = 10;
          if (low32[31]) begin
            text.push_back(ifmt_pkg::CH_MINUS);
            low32 = ~low32 + 32'd1;
            mag = {32'd0, low32};
          end
        end
        ifmt_pkg::MODE_UDEC: radix = 10;
        ifmt_pkg::MODE_HEXL: radix = 16;
        ifmt_pkg::MODE_HEXU: upper = 1'b1;
        ifmt_pkg::MODE_PTR: begin
          text.push_back(ifmt_pkg::CH_ZERO);
          text.push_back(ifmt_pkg::CH_X);
          mag = value;
        end
        default: return;
      endcase
      if (mode != ifmt_pkg::MODE_CHAR) begin
        do begin
          idx = int'(mag % radix);
          digs.push_front(upper ? digits_hi[idx] : digits_lo[idx]);
          mag = mag / radix;
        end while (mag != 0);
        foreach (digs[i]) text.push_back(digs[i]);
      end
      foreach (text[i]) begin
        item.ch = text[i];
        item.last = (i == text.size() - 1);
        expected_chars.push_back(item);
      end
    endfunction

    function void check_char(logic [ifmt_pkg::CharW-1:0] ch, logic last);
      char_item_t want;
      if (expected_chars.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: unexpected character %h last %b", ch, last);
        return;
      end
      want = expected_chars.pop_front();
      if (ch !== want.ch || last !== want.last) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected char %h last %b, got char %h last %b",
                   want.ch, want.last, ch, last);
      end
    endfunction

    function int unsigned pending();
      return expected_chars.size();
    endfunction

    function bit clean();
      return mismatches == 0 && expected_chars.size() == 0;
    endfunction
  endclass

  logic                           clk;
  logic                           rst_n;
  logic                           in_tvalid;
  logic                           in_tready;
  logic [ifmt_pkg::InDataW-1:0]   in_tdata;
  logic                           out_tvalid;
  logic                           out_tready;
  logic [ifmt_pkg::CharW-1:0]     out_tdata;
  logic                           out_tlast;

  conversion_checker conv_check;
  int unsigned idle_cycles = 0;

  integer_to_ascii_formatter u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic send_request(input logic [ifmt_pkg::ModeW-1:0] mode,
                              input logic [ifmt_pkg::ValueW-1:0] value,
                              input bit no_gap);
    int unsigned gap;
    gap = no_gap ? 0 : $urandom_range(0, MaxGap);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(ifmt_pkg::InDataW - ifmt_pkg::ModeW - ifmt_pkg::ValueW){1'b0}},
                  value, mode};
    do @(posedge clk); while (!in_tready);
    conv_check.note_request(mode, value);
  endtask

  // Directed requests: field extremes, every mode and the corner cases.
  task automatic send_directed();
    send_request(ifmt_pkg::MODE_CHAR, 64'h0, 1'b0);
    send_request(ifmt_pkg::MODE_CHAR, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
    send_request(ifmt_pkg::MODE_CHAR, 64'h25, 1'b0);
    send_request(ifmt_pkg::MODE_CHAR, 64'hA5A5_0000_1234_5641, 1'b0);
    send_request(ifmt_pkg::MODE_SDEC, 64'h0, 1'b1);
    send_request(ifmt_pkg::MODE_SDEC, 64'h0000_0000_FFFF_FFFF, 1'b0);
    send_request(ifmt_pkg::MODE_SDEC, 64'h0000_0000_8000_0000, 1'b1);
    send_request(ifmt_pkg::MODE_SDEC, 64'hFFFF_FFFF_7FFF_FFFF, 1'b0);
    send_request(ifmt_pkg::MODE_UDEC, 64'hFFFF_FFFF_0000_0000, 1'b0);
    send_request(ifmt_pkg::MODE_UDEC, 64'h0000_0000_FFFF_FFFF, 1'b1);
    send_request(ifmt_pkg::MODE_UDEC, 64'h0000_0000_3B9A_CA00, 1'b0);
    send_request(ifmt_pkg::MODE_UDEC, 64'h0000_0000_0000_0009, 1'b1);
    send_request(ifmt_pkg::MODE_HEXL, 64'h0, 1'b0);
    send_request(ifmt_pkg::MODE_HEXL, 64'h1234_5678_DEAD_BEEF, 1'b0);
    send_request(ifmt_pkg::MODE_HEXL, 64'h0000_0000_0000_0F00, 1'b1);
    send_request(ifmt_pkg::MODE_HEXU, 64'h0000_0000_FFFF_FFFF, 1'b0);
    send_request(ifmt_pkg::MODE_HEXU, 64'hFFFF_FFFF_ABCD_EF01, 1'b1);
    send_request(ifmt_pkg::MODE_HEXU, 64'h0, 1'b0);
    send_request(ifmt_pkg::MODE_PTR, 64'h0, 1'b0);
    send_request(ifmt_pkg::MODE_PTR, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
    send_request(ifmt_pkg::MODE_PTR, 64'h1, 1'b0);
    send_request(ifmt_pkg::MODE_PTR, 64'h8000_0000_0000_0000, 1'b0);
    send_request(3'd6, {$urandom, $urandom}, 1'b0);
    send_request(3'd7, {$urandom, $urandom}, 1'b1);
    send_request(ifmt_pkg::MODE_SDEC, 64'h0000_0000_FFFF_FF85, 1'b0);
  endtask

  initial begin
    logic [ifmt_pkg::ModeW-1:0]  mode;
    logic [ifmt_pkg::ValueW-1:0] value;
    int unsigned sent;
    conv_check = new();
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_directed();

    sent = 0;
    while (sent < RandomReqs) begin
      if ($urandom_range(0, 19) == 0) begin
        mode = 3'($urandom_range(6, 7));
      end else begin
        mode = 3'($urandom_range(0, 5));
        sent++;
      end
      value = {$urandom, $urandom};
      case ($urandom_range(0, 3))
        0: value = value;
        1: value = 64'($urandom_range(0, 99));
        2: value = value >> $urandom_range(0, 63);
        default: value[31:0] = 32'hFFFF_FFFF - 32'($urandom_range(0, 999));
      endcase
      send_request(mode, value, ((sent / 40) % 3) == 0);
      if (sent == 120) begin
        in_tvalid <= 1'b0;
        do @(posedge clk); while (conv_check.pending() != 0);
      end
    end
    in_tvalid <= 1'b0;

    while (conv_check.pending() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (conv_check.clean()) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    int unsigned chars_seen;
    int unsigned stall;
    chars_seen = 0;
    out_tready <= 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      if (chars_seen == 60) begin
        stall = LongHold;
      end else if (((chars_seen / 100) % 3) == 1) begin
        stall = 0;
      end else begin
        stall = $urandom_range(0, MaxGap);
      end
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      conv_check.check_char(out_tdata, out_tlast);
      chars_seen++;
    end
  end

  initial begin
    while (idle_cycles < IdleLimit) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("FAIL");
    $finish;
  end

endmodule
